>>> src/sacl_pkg.sv
// Shared constants, types and codes for the set-associative LRU tag tracker.
package sacl_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 4;
	localparam int ADDR_BITS    = 64;

	localparam int SETS      = 1 << MAX_SET_BITS;
	localparam int SET_W     = MAX_SET_BITS;
	localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAYS_W    = $clog2(MAX_WAYS + 1);
	localparam int AGE_W     = WAY_BITS;
	localparam int TAG_W     = ADDR_BITS - 2;
	localparam int SB_W      = 3;
	localparam int OB_W      = 6;
	localparam int SH_W      = OB_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;
	localparam int CNT_W     = 32;

	localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(MAX_WAYS - 1);

	// access kinds
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;

	// result codes
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

	localparam logic [SB_W-1:0]   SB_RESET   = 3'd4;
	localparam logic [OB_W-1:0]   OB_RESET   = 6'd4;
	localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(1);

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} way_t;

	typedef way_t [MAX_WAYS-1:0] set_word_t;

	localparam int WORD_W = $bits(set_word_t);

	typedef struct packed {
		set_word_t            word;
		logic [MAX_WAYS-1:0]  valid;
		logic [1:0]           outcome;
		logic                 hit;
		logic                 evict;
	} upd_t;

endpackage

>>> src/sacl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last word when no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/sacl_set_update.sv
// Lookup, replacement choice and LRU age update for one set.
module sacl_set_update (
	input  sacl_pkg::set_word_t                 rd_word,
	input  logic [sacl_pkg::MAX_WAYS-1:0]       rd_valid,
	input  logic [sacl_pkg::TAG_W-1:0]          tag,
	input  logic [sacl_pkg::WAYS_W-1:0]         ways,
	output sacl_pkg::upd_t                      upd
);
	import sacl_pkg::*;

	function automatic logic [AGE_W-1:0] grow(input logic [AGE_W-1:0] a);
		return (a == AGE_TOP) ? a : a + AGE_W'(1);
	endfunction

	logic [MAX_WAYS-1:0] used;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic                hit;
	logic                fill;
	logic [WAY_BITS-1:0] hit_way;
	logic [WAY_BITS-1:0] free_way;
	logic [WAY_BITS-1:0] victim;
	logic [AGE_W-1:0]    ref_age;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			used[w]  = (WAYS_W'(w) < ways);
			match[w] = used[w] && rd_valid[w] && (rd_word[w].tag == tag);
			free[w]  = used[w] && !rd_valid[w];
		end
		hit  = |match;
		fill = |free;
	end

	// lowest matching and lowest empty way win
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_BITS'(w);
			end
			if (free[w]) begin
				free_way = WAY_BITS'(w);
			end
		end
	end

	// oldest used way, lowest on a tie
	always_comb begin
		victim = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (used[w] && (rd_word[w].age > rd_word[victim].age)) begin
				victim = WAY_BITS'(w);
			end
		end
	end

	assign ref_age = rd_word[hit_way].age;

	always_comb begin
		upd.word    = rd_word;
		upd.valid   = rd_valid;
		upd.hit     = hit;
		upd.evict   = !hit && !fill;
		upd.outcome = hit ? OUT_HIT : (fill ? OUT_FILL : OUT_EVICT);
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (used[w]) begin
				if (hit) begin
					if (WAY_BITS'(w) == hit_way) begin
						upd.word[w].age = '0;
					end else if (rd_valid[w] && (rd_word[w].age < ref_age)) begin
						upd.word[w].age = grow(rd_word[w].age);
					end
				end else if (fill) begin
					if (WAY_BITS'(w) == free_way) begin
						upd.word[w].tag = tag;
						upd.word[w].age = '0;
						upd.valid[w]    = 1'b1;
					end else if (rd_valid[w]) begin
						upd.word[w].age = grow(rd_word[w].age);
					end
				end else begin
					if (WAY_BITS'(w) == victim) begin
						upd.word[w].tag = tag;
						upd.word[w].age = '0;
					end else begin
						upd.word[w].age = grow(rd_word[w].age);
					end
				end
			end
		end
	end

endmodule

>>> src/set_assoc_cache_lru_tracker.sv
// Top level of the set-associative cache tag tracker with true LRU replacement.
//
// Input channel (in_valid/in_ready, op, address): one data access per word.
// Output channel (out_valid/out_ready): one result word per access with the
// outcome (hit, fill of an empty way, eviction), the modify flag and the
// running hit, miss and eviction totals after that access.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 set index
// bits, 1 offset bits, 2 ways in use); index 3 is ignored. Write only while
// the block is idle.
// For each access, the accept cycle issues the read of the set word from
// the tag/age RAM; the lookup state then looks up all ways, picks the
// victim, writes the set back and loads the output register. A new access
// is accepted only once the previous one has written its set back (the
// single RAM read-modify-write per set), so accesses never overlap and no forwarding is involved.
// A result waiting in the output register does not block acceptance; the
// block holds in its lookup cycle only if the previous result is still not
// taken when the next one is ready. Reset clears all valid bits and totals
// at once; tag and age RAM contents are only read behind a set valid bit.
module set_assoc_cache_lru_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         op,
	input  logic [63:0]                        address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         outcome,
	output logic                               modify_hit,
	output logic [31:0]                        hits_total,
	output logic [31:0]                        misses_total,
	output logic [31:0]                        evictions_total,
	input  logic                               cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sacl_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
	import sacl_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic                state_q;
	logic [SB_W-1:0]     sb_q;
	logic [OB_W-1:0]     ob_q;
	logic [WAYS_W-1:0]   ways_q;

	logic [SB_W-1:0]     sb_eff;
	logic [OB_W-1:0]     ob_eff;
	logic [WAYS_W-1:0]   ways_eff;
	logic [SH_W-1:0]     tag_sh;
	logic [ADDR_BITS-1:0] addr;
	logic [ADDR_BITS-1:0] tag_full;
	logic [ADDR_BITS-1:0] set_full;
	logic [SET_W-1:0]    set_mask;
	logic [SET_W-1:0]    set_idx;

	logic [TAG_W-1:0]    tag_s1;
	logic [SET_W-1:0]    set_s1;
	logic                modify_s1;

	logic [MAX_WAYS-1:0] valid_q [SETS];
	logic [WORD_W-1:0]   rd_data;
	set_word_t           rd_word;
	upd_t                upd;

	logic                accept;
	logic                finish;

	logic                out_valid_q;
	logic [1:0]          outcome_q;
	logic                modify_q;
	logic [CNT_W-1:0]    hits_q;
	logic [CNT_W-1:0]    misses_q;
	logic [CNT_W-1:0]    evict_q;
	logic [1:0]          hit_add;

	// clamp registers to their working ranges
	always_comb begin
		sb_eff   = (sb_q == '0) ? SB_W'(1) :
			((sb_q > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : sb_q);
		ob_eff   = (ob_q == '0) ? OB_W'(1) : ob_q;
		ways_eff = (ways_q == '0) ? WAYS_W'(1) :
			((ways_q > WAYS_W'(MAX_WAYS)) ? WAYS_W'(MAX_WAYS) : ways_q);
	end

	// split the address into tag and set
	always_comb begin
		addr     = address[ADDR_BITS-1:0];
		tag_sh   = SH_W'(sb_eff) + SH_W'(ob_eff);
		tag_full = (tag_sh >= SH_W'(ADDR_BITS)) ? '0 : (addr >> tag_sh);
		set_full = addr >> ob_eff;
		set_mask = SET_W'((1 << sb_eff) - 1);
		set_idx  = set_full[SET_W-1:0] & set_mask;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign finish   = (state_q == ST_LOOK) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q   <= SB_RESET;
			ob_q   <= OB_RESET;
			ways_q <= WAYS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:    sb_q   <= cfg_wdata[SB_W-1:0];
				CFG_OFFSET_BITS: ob_q   <= cfg_wdata[OB_W-1:0];
				CFG_WAYS:        ways_q <= cfg_wdata[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1    <= tag_full[TAG_W-1:0];
			set_s1    <= set_idx;
			modify_s1 <= (op == OP_MODIFY);
		end
	end

	sacl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SETS)
	) u_ram (
		.clk   (clk),
		.we    (finish),
		.waddr (set_s1),
		.wdata (upd.word),
		.re    (accept),
		.raddr (set_idx),
		.rdata (rd_data)
	);

	assign rd_word = set_word_t'(rd_data);

	sacl_set_update u_update (
		.rd_word  (rd_word),
		.rd_valid (valid_q[set_s1]),
		.tag      (tag_s1),
		.ways     (ways_eff),
		.upd      (upd)
	);

	assign hit_add = {1'b0, upd.hit} + {1'b0, modify_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			evict_q     <= '0;
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (finish) begin
						state_q         <= ST_IDLE;
						out_valid_q     <= 1'b1;
						valid_q[set_s1] <= upd.valid;
						hits_q          <= hits_q + CNT_W'(hit_add);
						misses_q        <= misses_q + CNT_W'(!upd.hit);
						evict_q         <= evict_q + CNT_W'(upd.evict);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			outcome_q <= upd.outcome;
			modify_q  <= modify_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign outcome         = outcome_q;
	assign modify_hit      = modify_q;
	assign hits_total      = hits_q;
	assign misses_total    = misses_q;
	assign evictions_total = evict_q;

endmodule

>>> tb/set_assoc_cache_lru_tracker_tb.sv
// Self-checking testbench for the set-associative LRU cache tag tracker.
module set_assoc_cache_lru_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sacl_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  outcome;
		logic        modify_hit;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
	} access_result_t;

	class cache_outcome_scoreboard;
		logic [2:0] set_bits_reg;
		logic [5:0] offset_reg;
		logic [2:0] ways_reg;
		bit line_valid[SETS*MAX_WAYS];
		logic [63:0] line_tag[SETS*MAX_WAYS];
		int unsigned line_age[SETS*MAX_WAYS];
		logic [31:0] hits_seen, misses_seen, evict_count;
		access_result_t pending_outcomes[$];
		int errors, n_access, n_hit, n_fill, n_evict;

		function new();
			set_bits_reg = SB_RESET;
			offset_reg = OB_RESET;
			ways_reg = 3'(WAYS_RESET);
			foreach (line_valid[i]) begin
				line_valid[i] = 1'b0;
				line_tag[i] = '0;
				line_age[i] = 0;
			end
			hits_seen = '0;
			misses_seen = '0;
			evict_count = '0;
			errors = 0;
			n_access = 0;
			n_hit = 0;
			n_fill = 0;
			n_evict = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				CFG_SET_BITS: set_bits_reg = val[2:0];
				CFG_OFFSET_BITS: offset_reg = val[5:0];
				CFG_WAYS: ways_reg = val[2:0];
				default: ;
			endcase
		endfunction

		// clamp the raw registers to what the block actually uses
		function void effective(output int sb, output int ob, output int ways);
			sb = set_bits_reg;
			ob = offset_reg;
			ways = ways_reg;
			if (sb < 1) sb = 1;
			if (sb > MAX_SET_BITS) sb = MAX_SET_BITS;
			if (ob < 1) ob = 1;
			if (ways < 1) ways = 1;
			if (ways > MAX_WAYS) ways = MAX_WAYS;
		endfunction

		function int unsigned older(int unsigned a);
			return (a >= MAX_WAYS - 1) ? MAX_WAYS - 1 : a + 1;
		endfunction

		function void note_access(logic [1:0] kind, logic [63:0] addr);
			int sb, ob, ways, base, hit_way, victim;
			int unsigned hit_age;
			logic [63:0] tag, setsel;
			bit hit, filled;
			access_result_t r;
			effective(sb, ob, ways);
			tag = (sb + ob >= 64) ? 64'd0 : addr >> (sb + ob);
			setsel = (ob >= 64) ? 64'd0 : (addr >> ob) & ((64'd1 << sb) - 64'd1);
			base = int'(setsel) * MAX_WAYS;
			hit = 1'b0;
			filled = 1'b0;
			hit_way = 0;
			for (int w = 0; w < ways; w++) begin
				if (!hit && line_valid[base+w] && line_tag[base+w] == tag) begin
					hit = 1'b1;
					hit_way = w;
				end
			end
			if (hit) begin
				hit_age = line_age[base+hit_way];
				for (int w = 0; w < ways; w++)
					if (line_valid[base+w] && line_age[base+w] < hit_age)
						line_age[base+w] = older(line_age[base+w]);
				line_age[base+hit_way] = 0;
				hits_seen++;
				r.outcome = OUT_HIT;
				n_hit++;
			end else begin
				misses_seen++;
				for (int w = 0; w < ways; w++) begin
					if (!filled && !line_valid[base+w]) begin
						for (int k = 0; k < ways; k++)
							if (k != w && line_valid[base+k])
								line_age[base+k] = older(line_age[base+k]);
						line_valid[base+w] = 1'b1;
						line_tag[base+w] = tag;
						line_age[base+w] = 0;
						filled = 1'b1;
					end
				end
				if (filled) begin
					r.outcome = OUT_FILL;
					n_fill++;
				end else begin
					// oldest way goes, lowest index on a tie
					victim = 0;
					for (int w = 1; w < ways; w++)
						if (line_age[base+w] > line_age[base+victim])
							victim = w;
					for (int w = 0; w < ways; w++)
						if (w != victim)
							line_age[base+w] = older(line_age[base+w]);
					line_tag[base+victim] = tag;
					line_age[base+victim] = 0;
					evict_count++;
					r.outcome = OUT_EVICT;
					n_evict++;
				end
			end
			if (kind == OP_MODIFY)
				hits_seen++;
			r.modify_hit = (kind == OP_MODIFY);
			r.hits = hits_seen;
			r.misses = misses_seen;
			r.evictions = evict_count;
			pending_outcomes.push_back(r);
			n_access++;
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(access_result_t got);
			access_result_t want;
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, actual %0h", $time, got);
				return;
			end
			want = pending_outcomes.pop_front();
			compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
			compare_field("modify_hit", 32'(want.modify_hit), 32'(got.modify_hit));
			compare_field("hits_total", want.hits, got.hits);
			compare_field("misses_total", want.misses, got.misses);
			compare_field("evictions_total", want.evictions, got.evictions);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_LOAD;
	logic [63:0] address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] outcome;
	logic modify_hit;
	logic [31:0] hits_total, misses_total, evictions_total;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	cache_outcome_scoreboard outcomes = new();
	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int settings_run = 0;

	set_assoc_cache_lru_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.modify_hit(modify_hit),
		.hits_total(hits_total),
		.misses_total(misses_total),
		.evictions_total(evictions_total),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			outcomes.note_access(op, address);
	end

	// check result words and throttle out_ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			outcomes.check_result({outcome, modify_hit, hits_total, misses_total,
				evictions_total});
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send(input logic [1:0] kind, input logic [63:0] addr);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		address <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drop valid and let every outstanding result drain
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcomes.pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [5:0] sbv, input logic [5:0] obv,
			input logic [5:0] wv);
		logic [CFG_DAT_W-1:0] junk;
		junk = CFG_DAT_W'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SET_BITS;
		cfg_wdata <= sbv;
		@(posedge clk);
		outcomes.write_reg(CFG_SET_BITS, sbv);
		cfg_index <= CFG_OFFSET_BITS;
		cfg_wdata <= obv;
		@(posedge clk);
		outcomes.write_reg(CFG_OFFSET_BITS, obv);
		cfg_index <= CFG_WAYS;
		cfg_wdata <= wv;
		@(posedge clk);
		outcomes.write_reg(CFG_WAYS, wv);
		// unused index must leave every register alone
		cfg_index <= CFG_NONE;
		cfg_wdata <= junk;
		@(posedge clk);
		outcomes.write_reg(CFG_NONE, junk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 15);
		if (r < 5) return OP_LOAD;
		if (r < 10) return OP_STORE;
		if (r < 15) return OP_MODIFY;
		return OP_UNKNOWN;
	endfunction

	// mostly a small pool of tags and sets so hits and evictions are common
	function automatic logic [63:0] pick_addr();
		int sb, ob, ways;
		logic [63:0] tag, setsel, off;
		outcomes.effective(sb, ob, ways);
		if ($urandom_range(0, 99) < 12)
			return {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			tag = {$urandom, $urandom};
		else
			tag = 64'($urandom_range(0, ways + 2));
		if ($urandom_range(0, 7) == 0)
			setsel = {$urandom, $urandom};
		else
			setsel = 64'($urandom_range(0, 3));
		off = {$urandom, $urandom};
		return (off & ((64'd1 << ob) - 64'd1)) |
			((setsel & ((64'd1 << sb) - 64'd1)) << ob) |
			((sb + ob >= 64) ? 64'd0 : tag << (sb + ob));
	endfunction

	task automatic run_phase(input logic [5:0] sbv, input logic [5:0] obv,
			input logic [5:0] wv, input int count, input bit idles);
		drain();
		set_regs(sbv, obv, wv);
		idle_on = idles;
		repeat (count) send(pick_op(), pick_addr());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 16 sets, 16-byte lines, direct mapped
		send(OP_LOAD, 64'h0);
		send(OP_LOAD, 64'h0);
		send(OP_STORE, 64'h8);
		send(OP_MODIFY, 64'h10);
		send(OP_LOAD, '1);
		send(OP_UNKNOWN, '1);
		send(OP_LOAD, 64'h100);
		send(OP_MODIFY, 64'h0);

		// four ways, one set filled, then replaced in LRU order
		drain();
		set_regs(6'd2, 6'd3, 6'd4);
		send(OP_LOAD, 64'd0 << 5);
		send(OP_LOAD, 64'd1 << 5);
		send(OP_STORE, 64'd2 << 5);
		send(OP_LOAD, 64'd3 << 5);
		send(OP_MODIFY, 64'd0 << 5);
		send(OP_LOAD, 64'd4 << 5);
		send(OP_LOAD, 64'd1 << 5);
		send(OP_STORE, 64'd0 << 5);
		send(OP_LOAD, 64'd3 << 5);
		send(OP_UNKNOWN, 64'd5 << 5);
		send(OP_LOAD, 64'h5555_5555_5555_5555);
		send(OP_STORE, 64'haaaa_aaaa_aaaa_aaaa);

		run_phase(6'd3, 6'd4, 6'd4, 150, 1'b1);
		run_phase(6'd1, 6'd1, 6'd2, 100, 1'b1);
		run_phase(6'd6, 6'd32, 6'd4, 120, 1'b1);
		run_phase(6'd0, 6'd0, 6'd0, 60, 1'b1);
		run_phase(6'd7, 6'd63, 6'd7, 80, 1'b1);
		run_phase(6'd6, 6'd58, 6'd4, 60, 1'b1);
		// lower the way count and raise it again with the same geometry
		run_phase(6'd2, 6'd6, 6'd4, 150, 1'b1);
		run_phase(6'd2, 6'd6, 6'd2, 100, 1'b1);
		run_phase(6'd2, 6'd6, 6'd4, 100, 1'b1);
		run_phase(6'd4, 6'd12, 6'd3, 200, 1'b0);
		drain();

		$display("covered %0d accesses under %0d register settings", outcomes.n_access,
			settings_run + 1);
		$display("outcomes seen: %0d hits, %0d fills, %0d evictions", outcomes.n_hit,
			outcomes.n_fill, outcomes.n_evict);
		if (outcomes.errors == 0 && outcomes.pending_outcomes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
